// ===== rtl/pdir_pkg.sv =====
// Shared types and constants for the pulse-distance IR frame receiver.
// Has no dependencies; every other file imports it.
`default_nettype none

package pdir_pkg;

  // Frame limit and run timer width.
  localparam int MAX_BYTES  = 32;
  localparam int TIMER_BITS = 16;

  // Width of the threshold registers and of the compare path.
  localparam int THR_W   = 16;
  localparam int CMP_W   = (TIMER_BITS > THR_W) ? TIMER_BITS : THR_W;
  localparam int BYTES_W = $clog2(MAX_BYTES + 1);

  // Sample queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [2:0] CFG_START_BURST_MIN = 3'd0;
  localparam logic [2:0] CFG_START_BURST_MAX = 3'd1;
  localparam logic [2:0] CFG_START_GAP_MAX   = 3'd2;
  localparam logic [2:0] CFG_SHORT_MIN       = 3'd3;
  localparam logic [2:0] CFG_LONG_MIN        = 3'd4;
  localparam logic [2:0] CFG_BIT_TIMEOUT     = 3'd5;
  localparam logic [2:0] CFG_DEVICE_ID       = 3'd6;

  // Frame status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TIMING   = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;
  localparam logic [2:0] ST_ADDRESS  = 3'd5;

  // Decoder phases.
  typedef enum logic [1:0] {
    PH_HUNT      = 2'd0,
    PH_START_GAP = 2'd1,
    PH_BURST     = 2'd2,
    PH_GAP       = 2'd3
  } phase_t;

  // Timing and address settings as seen by the decoder.
  typedef struct packed {
    logic [THR_W-1:0] start_burst_min;
    logic [THR_W-1:0] start_burst_max;
    logic [THR_W-1:0] start_gap_max;
    logic [THR_W-1:0] short_min;
    logic [THR_W-1:0] long_min;
    logic [THR_W-1:0] bit_timeout;
    logic [7:0]       device_id;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/pdir_cfg_regs.sv =====
// Configuration register file of the IR frame receiver.
// Depends on pdir_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module pdir_cfg_regs
  import pdir_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [THR_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register write; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_burst_min <= THR_W'(4000);
      cfg.start_burst_max <= THR_W'(6000);
      cfg.start_gap_max   <= THR_W'(6000);
      cfg.short_min       <= THR_W'(250);
      cfg.long_min        <= THR_W'(750);
      cfg.bit_timeout     <= THR_W'(1250);
      cfg.device_id       <= 8'd48;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_BURST_MIN: cfg.start_burst_min <= cfg_data;
        CFG_START_BURST_MAX: cfg.start_burst_max <= cfg_data;
        CFG_START_GAP_MAX:   cfg.start_gap_max   <= cfg_data;
        CFG_SHORT_MIN:       cfg.short_min       <= cfg_data;
        CFG_LONG_MIN:        cfg.long_min        <= cfg_data;
        CFG_BIT_TIMEOUT:     cfg.bit_timeout     <= cfg_data;
        CFG_DEVICE_ID:       cfg.device_id       <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pdir_queue.sv =====
// Front end: accepts receiver samples and holds them in a short queue.
// Depends on pdir_pkg for the queue depth and pointer widths.
`default_nettype none

module pdir_queue
  import pdir_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic rx_level,
  output logic      q_valid,
  output logic      q_level,
  input  wire logic q_pop
);

  logic [QUEUE_DEPTH-1:0] slots;
  logic [QPTR_W-1:0]      wr_ptr;
  logic [QPTR_W-1:0]      rd_ptr;
  logic [QCNT_W-1:0]      fill;
  logic                   push;
  logic                   pop;

  assign in_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (fill != '0);
  assign q_level  = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Sample storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= rx_level;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pdir_decoder.sv =====
// Back end: decodes one queued sample per cycle while the result register
// is free or read, and registers the byte or frame result. Needs pdir_pkg.
`default_nettype none

module pdir_decoder
  import pdir_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  wire logic q_valid,
  input  wire logic q_level,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic      byte_valid,
  output logic [7:0] data_byte,
  output logic [4:0] byte_index,
  output logic      frame_done,
  output logic [2:0] status,
  output logic [5:0] byte_count
);

  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] run_ticks, run_ticks_next;
  logic [7:0]            shift_bits, shift_bits_next;
  logic [2:0]            bit_slot, bit_slot_next;
  logic [BYTES_W-1:0]    bytes_done, bytes_done_next;
  logic [7:0]            xor_sum, xor_sum_next;
  logic [7:0]            first_byte, first_byte_next;
  logic                  out_valid_next;

  logic                  step;
  logic                  high;
  logic [TIMER_BITS-1:0] run_inc;
  logic [CMP_W-1:0]      run_x;
  logic [CMP_W-1:0]      run_inc_x;
  logic                  start_ok;
  logic                  gap_zero;
  logic                  gap_over;
  logic                  tmo_zero;
  logic                  inc_over;
  logic                  is_long;
  logic                  is_short;
  logic                  gap_ok;
  logic                  bit_ok;
  logic                  slot_wrap;
  logic [BYTES_W-1:0]    bytes_inc;
  logic                  ovf;
  logic [7:0]            new_shift;
  logic                  fin;
  logic [2:0]            fin_st;
  logic                  emit;

  // One sample is decoded whenever the result register can take a result.
  assign step  = q_valid && (!out_valid || out_ready);
  assign q_pop = step;
  assign high  = q_level;

  // Run timer and the comparisons against the thresholds.
  assign run_inc   = (run_ticks == {TIMER_BITS{1'b1}}) ? run_ticks : run_ticks + 1'b1;
  assign run_x     = CMP_W'(run_ticks);
  assign run_inc_x = CMP_W'(run_inc);
  assign start_ok  = (run_x >= CMP_W'(cfg.start_burst_min)) &&
                     (run_x <= CMP_W'(cfg.start_burst_max)) && (run_ticks != '0);
  assign gap_zero  = (cfg.start_gap_max == '0);
  assign gap_over  = (run_inc_x > CMP_W'(cfg.start_gap_max));
  assign tmo_zero  = (cfg.bit_timeout == '0);
  assign inc_over  = (run_inc_x > CMP_W'(cfg.bit_timeout));
  assign is_long   = (run_x > CMP_W'(cfg.long_min));
  assign is_short  = (run_x < CMP_W'(cfg.short_min));
  assign gap_ok    = (run_x > CMP_W'(cfg.short_min));
  assign bit_ok    = is_long || gap_ok;
  assign slot_wrap = (bit_slot == 3'd7);
  assign bytes_inc = bytes_done + 1'b1;
  assign ovf       = (bytes_inc >= BYTES_W'(MAX_BYTES));
  assign new_shift = {shift_bits[6:0], is_long};

  // Classify the sample: does it finish the frame or complete a byte.
  always_comb begin
    fin    = 1'b0;
    fin_st = ST_OK;
    emit   = 1'b0;
    unique case (phase)
      PH_HUNT: begin
      end
      PH_START_GAP: begin
        fin    = !high && tmo_zero;
        fin_st = ST_TIMING;
      end
      PH_BURST: begin
        if (!high) begin
          fin    = inc_over;
          fin_st = ST_TIMING;
        end else if (is_long) begin
          // End mark: empty, then checksum, then address.
          fin = 1'b1;
          if (bytes_done == '0) begin
            fin_st = ST_EMPTY;
          end else if (xor_sum != 8'd0) begin
            fin_st = ST_CHECKSUM;
          end else if (first_byte != cfg.device_id) begin
            fin_st = ST_ADDRESS;
          end else begin
            fin_st = ST_OK;
          end
        end else begin
          fin    = is_short || tmo_zero;
          fin_st = ST_TIMING;
        end
      end
      PH_GAP: begin
        if (high) begin
          fin    = inc_over;
          fin_st = ST_TIMING;
        end else if (!bit_ok) begin
          fin    = 1'b1;
          fin_st = ST_TIMING;
        end else begin
          emit = slot_wrap;
          if (slot_wrap && ovf) begin
            fin    = 1'b1;
            fin_st = ST_OVERFLOW;
          end else begin
            fin    = tmo_zero;
            fin_st = ST_TIMING;
          end
        end
      end
    endcase
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (step) begin
      if (fin) begin
        phase_next = PH_HUNT;
      end else begin
        unique case (phase)
          PH_HUNT:      phase_next = (high && start_ok && !gap_zero) ? PH_START_GAP : PH_HUNT;
          PH_START_GAP: phase_next = high ? (gap_over ? PH_HUNT : PH_START_GAP) : PH_BURST;
          PH_BURST:     phase_next = high ? PH_GAP : PH_BURST;
          PH_GAP:       phase_next = high ? PH_GAP : PH_BURST;
        endcase
      end
    end
  end

  // Timer, byte assembly and frame totals.
  always_comb begin
    run_ticks_next  = run_ticks;
    shift_bits_next = shift_bits;
    bit_slot_next   = bit_slot;
    bytes_done_next = bytes_done;
    xor_sum_next    = xor_sum;
    first_byte_next = first_byte;
    if (step) begin
      unique case (phase)
        PH_HUNT: begin
          if (!high) begin
            run_ticks_next = run_inc;
          end else if (start_ok && !gap_zero) begin
            run_ticks_next = TIMER_BITS'(1);
          end else begin
            run_ticks_next = '0;
          end
        end
        PH_START_GAP: begin
          if (high) begin
            run_ticks_next = gap_over ? '0 : run_inc;
          end else begin
            run_ticks_next  = TIMER_BITS'(1);
            shift_bits_next = 8'd0;
            bit_slot_next   = 3'd0;
            bytes_done_next = '0;
            xor_sum_next    = 8'd0;
            first_byte_next = 8'd0;
          end
        end
        PH_BURST: begin
          run_ticks_next = high ? TIMER_BITS'(1) : run_inc;
        end
        PH_GAP: begin
          if (high) begin
            run_ticks_next = run_inc;
          end else begin
            run_ticks_next = TIMER_BITS'(1);
            if (bit_ok) begin
              bit_slot_next = bit_slot + 1'b1;
              if (slot_wrap) begin
                shift_bits_next = 8'd0;
                xor_sum_next    = xor_sum ^ new_shift;
                bytes_done_next = bytes_inc;
                if (bytes_done == '0) begin
                  first_byte_next = new_shift;
                end
              end else begin
                shift_bits_next = new_shift;
              end
            end
          end
        end
      endcase
      if (fin) begin
        run_ticks_next = '0;
      end
    end
  end

  // Result register handshake.
  assign out_valid_next = step ? (fin || emit) : (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      run_ticks  <= '0;
      shift_bits <= 8'd0;
      bit_slot   <= 3'd0;
      bytes_done <= '0;
      xor_sum    <= 8'd0;
      first_byte <= 8'd0;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      run_ticks  <= run_ticks_next;
      shift_bits <= shift_bits_next;
      bit_slot   <= bit_slot_next;
      bytes_done <= bytes_done_next;
      xor_sum    <= xor_sum_next;
      first_byte <= first_byte_next;
      out_valid  <= out_valid_next;
    end
  end

  // Result fields; fields of the part that did not happen read as zero.
  always_ff @(posedge clk) begin
    if (step && (fin || emit)) begin
      byte_valid <= emit;
      data_byte  <= emit ? new_shift : 8'd0;
      byte_index <= emit ? 5'(bytes_done) : 5'd0;
      frame_done <= fin;
      status     <= fin ? fin_st : ST_OK;
      byte_count <= fin ? 6'(bytes_done_next) : 6'd0;
    end
  end

`ifndef SYNTH
  // A delivered result always carries a byte or a frame end.
  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid || frame_done))
    else $error("result beat with neither byte nor frame end");

  // Overflow is only reported together with the byte that caused it.
  a_overflow_with_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done && (status == ST_OVERFLOW)) |-> byte_valid)
    else $error("overflow status without its byte");

  // A finished frame sends the decoder back to hunting with a clear timer.
  a_finish_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (step && fin) |=> ((phase == PH_HUNT) && (run_ticks == '0)))
    else $error("decoder did not return to hunting after frame end");

  // The byte counter never passes the frame limit.
  a_bytes_bounded: assert property (@(posedge clk) disable iff (rst)
    bytes_done <= BYTES_W'(MAX_BYTES))
    else $error("byte counter beyond frame limit");

  // The decoder only consumes samples when the queue holds one.
  a_pop_needs_sample: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("sample taken from an empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/pulse_distance_ir_frame_receiver_core.sv =====
// A sample passes the queue slots, then is decoded into the result register.
// Throughput: one receiver sample per clock while the result register is
// free or read; a four-beat sample queue absorbs output stalls.
// Reset (rst, synchronous, active high) empties the queue, returns the
// decoder to hunting with all counters cleared, and loads the default
// timing and address settings.
// Top level: instantiates pdir_cfg_regs, pdir_queue and pdir_decoder.
`default_nettype none

module pulse_distance_ir_frame_receiver_core
  import pdir_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             rx_level,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  byte_valid,
  output logic [7:0]            data_byte,
  output logic [4:0]            byte_index,
  output logic                  frame_done,
  output logic [2:0]            status,
  output logic [5:0]            byte_count,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [THR_W-1:0] cfg_data
);

  cfg_t cfg;
  logic q_valid;
  logic q_level;
  logic q_pop;

  // Settings.
  pdir_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sample intake.
  pdir_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_level (rx_level),
    .q_valid  (q_valid),
    .q_level  (q_level),
    .q_pop    (q_pop)
  );

  // Frame decoding and result register.
  pdir_decoder u_decoder (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_level    (q_level),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte_valid (byte_valid),
    .data_byte  (data_byte),
    .byte_index (byte_index),
    .frame_done (frame_done),
    .status     (status),
    .byte_count (byte_count)
  );

endmodule

`default_nettype wire

// ===== tb/tb_pulse_distance_ir_frame_receiver_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pulse_distance_ir_frame_receiver_core.
// Depends on pdir_pkg and the core; a scoreboard class decodes every sample beat it is told of.

module tb_pulse_distance_ir_frame_receiver_core;
  import pdir_pkg::*;

  localparam int SETTLE_CYCLES      = 16;
  localparam int RANDOM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE    = 260;
  localparam int MIN_RANDOM_REPORTS = 48;

  localparam cfg_t DEFAULT_TIMING = '{16'd4000, 16'd6000, 16'd6000, 16'd250, 16'd750,
                                      16'd1250, 8'd48};

  // One output beat: a finished byte, a frame end, or both.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [4:0] byte_index;
    logic       frame_done;
    logic [2:0] status;
    logic [5:0] byte_count;
  } ir_report_t;

  // Decodes the pin samples on its own and checks the reports of the core.
  class frame_scoreboard;
    cfg_t                  regs;
    phase_t                ph;
    logic [TIMER_BITS-1:0] run_len;
    logic [7:0]            shifter;
    logic [2:0]            slot;
    logic [5:0]            byte_total;
    logic [7:0]            parity;
    logic [7:0]            lead_byte;
    ir_report_t            due_reports[$];
    ir_report_t            draft;
    bit                    draft_set;
    int                    mismatches;
    int                    reports_seen;

    function new();
      regs         = DEFAULT_TIMING;
      ph           = PH_HUNT;
      run_len      = '0;
      shifter      = '0;
      slot         = '0;
      byte_total   = '0;
      parity       = '0;
      lead_byte    = '0;
      mismatches   = 0;
      reports_seen = 0;
    endfunction

    function void set_register(logic [2:0] index, logic [THR_W-1:0] value);
      case (index)
        CFG_START_BURST_MIN: regs.start_burst_min = value;
        CFG_START_BURST_MAX: regs.start_burst_max = value;
        CFG_START_GAP_MAX:   regs.start_gap_max   = value;
        CFG_SHORT_MIN:       regs.short_min       = value;
        CFG_LONG_MIN:        regs.long_min        = value;
        CFG_BIT_TIMEOUT:     regs.bit_timeout     = value;
        CFG_DEVICE_ID:       regs.device_id       = value[7:0];
        default: ;
      endcase
    endfunction

    // The run timer saturates instead of wrapping.
    function logic [TIMER_BITS-1:0] bump(logic [TIMER_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void close_frame(logic [2:0] code);
      draft.frame_done = 1'b1;
      draft.status     = code;
      draft.byte_count = byte_total;
      ph               = PH_HUNT;
      run_len          = '0;
      draft_set        = 1'b1;
    endfunction

    // Advances the decoder by one sample and queues the report it causes.
    function void note_sample(logic level);
      draft     = '0;
      draft_set = 1'b0;
      case (ph)
        PH_HUNT: begin
          if (!level) begin
            run_len = bump(run_len);
          end else if (run_len >= regs.start_burst_min && run_len <= regs.start_burst_max &&
                       run_len != 0) begin
            ph      = PH_START_GAP;
            run_len = 1;
            if (run_len > regs.start_gap_max) begin
              ph      = PH_HUNT;
              run_len = '0;
            end
          end else begin
            run_len = '0;
          end
        end
        PH_START_GAP: begin
          if (level) begin
            run_len = bump(run_len);
            if (run_len > regs.start_gap_max) begin
              ph      = PH_HUNT;
              run_len = '0;
            end
          end else begin
            ph         = PH_BURST;
            run_len    = 1;
            shifter    = '0;
            slot       = '0;
            byte_total = '0;
            parity     = '0;
            lead_byte  = '0;
            if (run_len > regs.bit_timeout) close_frame(ST_TIMING);
          end
        end
        PH_BURST: begin
          if (!level) begin
            run_len = bump(run_len);
            if (run_len > regs.bit_timeout) close_frame(ST_TIMING);
          end else if (run_len > regs.long_min) begin
            // End mark: checksum is judged before the address.
            if (byte_total == 0) close_frame(ST_EMPTY);
            else if (parity != 0) close_frame(ST_CHECKSUM);
            else if (lead_byte != regs.device_id) close_frame(ST_ADDRESS);
            else close_frame(ST_OK);
          end else if (run_len < regs.short_min) begin
            close_frame(ST_TIMING);
          end else begin
            ph      = PH_GAP;
            run_len = 1;
            if (run_len > regs.bit_timeout) close_frame(ST_TIMING);
          end
        end
        default: begin
          if (level) begin
            run_len = bump(run_len);
            if (run_len > regs.bit_timeout) close_frame(ST_TIMING);
          end else if (run_len > regs.long_min || run_len > regs.short_min) begin
            shifter = {shifter[6:0], run_len > regs.long_min};
            slot    = slot + 1'b1;
            ph      = PH_BURST;
            run_len = 1;
            if (slot == 0) begin
              draft.byte_valid = 1'b1;
              draft.data_byte  = shifter;
              draft.byte_index = byte_total[4:0];
              draft_set        = 1'b1;
              parity           = parity ^ shifter;
              if (byte_total == 0) lead_byte = shifter;
              byte_total = byte_total + 1'b1;
              shifter    = '0;
            end
            if (slot == 0 && byte_total >= MAX_BYTES) close_frame(ST_OVERFLOW);
            else if (run_len > regs.bit_timeout) close_frame(ST_TIMING);
          end else begin
            close_frame(ST_TIMING);
          end
        end
      endcase
      if (draft_set) due_reports.push_back(draft);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compares one output beat with the oldest pending report.
    function void check_result(ir_report_t got);
      ir_report_t want;
      reports_seen++;
      if (due_reports.size() == 0) begin
        mismatches++;
        $display("%0t: report with none pending, expected nothing, actual %h", $time, got);
        return;
      end
      want = due_reports.pop_front();
      compare_field("byte_valid", want.byte_valid, got.byte_valid);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("frame_done", want.frame_done, got.frame_done);
      compare_field("status", want.status, got.status);
      compare_field("byte_count", want.byte_count, got.byte_count);
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             rx_level  = 1'b1;
  logic             out_ready = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [2:0]       cfg_index = CFG_START_BURST_MIN;
  logic [THR_W-1:0] cfg_data  = '0;
  logic             in_ready;
  logic             out_valid;
  logic             cfg_ready;
  logic             byte_valid;
  logic [7:0]       data_byte;
  logic [4:0]       byte_index;
  logic             frame_done;
  logic [2:0]       status;
  logic [5:0]       byte_count;

  frame_scoreboard  sb;
  cfg_t             timing      = DEFAULT_TIMING;
  int               in_gap_max  = 0;
  int               out_gap_max = 14;
  int               out_hold    = 0;
  int               samples_sent = 0;
  bit               fault_on    = 1'b0;
  logic [7:0]       frame_bytes[$];
  ir_report_t       seen;

  pulse_distance_ir_frame_receiver_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_level   (rx_level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte_valid (byte_valid),
    .data_byte  (data_byte),
    .byte_index (byte_index),
    .frame_done (frame_done),
    .status     (status),
    .byte_count (byte_count),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Output side: check each accepted beat, then hold ready low for a random stall.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else if (out_valid && out_ready) begin
      seen = '{byte_valid, data_byte, byte_index, frame_done, status, byte_count};
      sb.check_result(seen);
      out_hold = $urandom_range(out_gap_max, 0);
      out_ready <= (out_hold == 0);
    end else if (out_hold != 0) begin
      out_hold = out_hold - 1;
      out_ready <= (out_hold == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int pick(int lo, int hi);
    return $urandom_range(hi, lo);
  endfunction

  // Offers one sample beat; valid stays high into the next beat unless a pause follows.
  task automatic send_sample(input logic level);
    int pause;
    in_valid <= 1'b1;
    rx_level <= level;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(level);
    samples_sent++;
    pause = $urandom_range(in_gap_max, 0);
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
  endtask

  task automatic send_run(input logic level, input int len);
    repeat (len) send_sample(level);
  endtask

  // Stops offering samples and waits until the core has nothing left in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [THR_W-1:0] value,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(index, value);
    if (last) cfg_valid <= 1'b0;
  endtask

  // Writes every register while the core is idle.
  task automatic load_settings(input cfg_t s);
    logic [7:0] junk;
    junk = $urandom;
    settle();
    write_reg(CFG_START_BURST_MIN, s.start_burst_min, 1'b0);
    write_reg(CFG_START_BURST_MAX, s.start_burst_max, 1'b0);
    write_reg(CFG_START_GAP_MAX, s.start_gap_max, 1'b0);
    write_reg(CFG_SHORT_MIN, s.short_min, 1'b0);
    write_reg(CFG_LONG_MIN, s.long_min, 1'b0);
    write_reg(CFG_BIT_TIMEOUT, s.bit_timeout, 1'b0);
    write_reg(CFG_DEVICE_ID, {junk, s.device_id}, 1'b1);
    timing = s;
  endtask

  // One data bit: a short burst, then a long gap for 1 or a short gap for 0.
  task automatic send_bit(input logic value);
    int burst;
    int gap;
    burst = pick((timing.short_min == 0) ? 1 : timing.short_min, timing.long_min);
    gap   = value ? pick(timing.long_min + 1, timing.bit_timeout)
                  : pick(timing.short_min + 1, timing.long_min);
    if (fault_on && $urandom_range(0, 63) == 0) burst = pick(1, timing.bit_timeout + 2);
    if (fault_on && $urandom_range(0, 63) == 0) gap = pick(1, timing.bit_timeout + 2);
    send_run(1'b0, burst);
    send_run(1'b1, gap);
  endtask

  task automatic send_byte(input logic [7:0] value);
    for (int i = 7; i >= 0; i--) send_bit(value[i]);
  endtask

  task automatic send_start();
    send_run(1'b0, pick((timing.start_burst_min == 0) ? 1 : timing.start_burst_min,
                        timing.start_burst_max));
    send_run(1'b1, pick(1, timing.start_gap_max));
  endtask

  task automatic send_end();
    send_run(1'b0, pick(timing.long_min + 1, timing.bit_timeout));
    send_run(1'b1, 1);
  endtask

  // Start burst, the bytes in frame_bytes, some loose bits, then the end mark.
  task automatic send_frame(input int tail_bits);
    send_start();
    foreach (frame_bytes[k]) send_byte(frame_bytes[k]);
    repeat (tail_bits) send_bit($urandom_range(0, 1));
    send_end();
  endtask

  // Mostly sound frames: address and checksum usually right, sometimes a full frame.
  task automatic random_frame();
    int count;
    logic [7:0] sum;
    frame_bytes.delete();
    count = ($urandom_range(0, 49) == 0) ? MAX_BYTES : $urandom_range(0, 4);
    for (int k = 0; k < count; k++) frame_bytes.push_back($urandom);
    if (count != 0 && $urandom_range(0, 3) != 0) frame_bytes[0] = timing.device_id;
    if (count > 1 && $urandom_range(0, 3) != 0) begin
      sum = '0;
      for (int k = 0; k < count - 1; k++) sum = sum ^ frame_bytes[k];
      frame_bytes[count-1] = sum;
    end
    send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0);
    send_run(1'b1, $urandom_range(0, 3));
  endtask

  task automatic send_noise();
    int runs;
    runs = $urandom_range(2, 10);
    for (int k = 0; k < runs; k++)
      send_run($urandom_range(0, 1), pick(1, timing.bit_timeout + timing.start_gap_max));
  endtask

  function automatic cfg_t random_timing(int p);
    cfg_t s;
    s.short_min       = (p == 2) ? 16'd0 : 16'($urandom_range(1, 4));
    s.long_min        = s.short_min + 16'($urandom_range(2, 4));
    s.bit_timeout     = s.long_min + 16'($urandom_range(1, 4));
    s.start_burst_min = (p == 3) ? 16'd0 : 16'($urandom_range(1, 5));
    s.start_burst_max = s.start_burst_min + 16'($urandom_range(0, 3));
    s.start_gap_max   = 16'($urandom_range(1, 5));
    s.device_id       = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom);
    return s;
  endfunction

  // Fixed ceiling on the run time.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int phase_base;
    int report_base;
    bit pressed;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one clean two-byte frame at full length, no idling.
    frame_bytes = '{8'h30, 8'h30};
    send_frame(0);

    // Short timings for the directed frames.
    load_settings('{16'd2, 16'd4, 16'd3, 16'd2, 16'd4, 16'd6, 8'hA5});
    in_gap_max = 14;
    send_run(1'b1, 3);
    // Start bursts that are too short and too long are dropped.
    send_run(1'b0, 1);
    send_run(1'b1, 2);
    send_run(1'b0, 5);
    send_run(1'b1, 2);
    // Start gap too long: back to hunting with no report.
    send_run(1'b0, 3);
    send_run(1'b1, 5);
    // End mark right after the start: empty frame.
    send_start();
    send_end();
    // Good frame, bad checksum, wrong address, then loose bits before the end mark.
    frame_bytes = '{8'hA5, 8'h3C, 8'h99};
    send_frame(0);
    frame_bytes = '{8'hA5, 8'h01};
    send_frame(0);
    frame_bytes = '{8'h5A, 8'h5A};
    send_frame(0);
    frame_bytes = '{8'hA5, 8'hA5};
    send_frame(3);
    // Burst too short after one byte.
    send_start();
    send_byte(8'hA5);
    send_run(1'b0, 1);
    send_run(1'b1, 3);
    // Gap too short, then gap too long.
    send_start();
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    send_run(1'b0, 2);
    send_run(1'b1, 3);
    send_start();
    send_run(1'b0, 2);
    send_run(1'b1, 7);
    // Burst too long; the low that goes on after the abort is a new start burst.
    send_start();
    send_byte(8'hA5);
    send_run(1'b0, 10);
    send_run(1'b1, 2);
    send_byte(8'hA5);
    send_byte(8'hA5);
    send_end();
    // Byte limit reached before the end mark.
    frame_bytes.delete();
    repeat (MAX_BYTES) frame_bytes.push_back($urandom);
    send_frame(0);

    // Zero thresholds: no start qualifies, then an instant burst timeout, then an empty frame.
    load_settings('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00});
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    load_settings('{16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0, 8'h00});
    send_run(1'b0, 1);
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    load_settings('{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 8'hFF});
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 3);
    send_run(1'b1, 1);

    // Full-scale thresholds: the start burst saturates the run timer.
    load_settings('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd2, 16'd4, 16'hFFFF, 8'hFF});
    in_gap_max = 0;
    send_run(1'b0, 65540);
    send_run(1'b1, 3);
    repeat (8) begin
      send_run(1'b0, 3);
      send_run(1'b1, 6);
    end
    send_run(1'b0, 10);
    send_run(1'b1, 1);

    // Random frames and noise under several random settings.
    report_base = sb.reports_seen;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_settings(random_timing(p));
      fault_on   = 1'b1;
      phase_base = samples_sent;
      pressed    = 1'b0;
      while ((samples_sent - phase_base) < ITEMS_PER_PHASE ||
             (p == RANDOM_PHASES - 1 && sb.reports_seen - report_base < MIN_RANDOM_REPORTS))
      begin
        case ($urandom_range(0, 2))
          0:       in_gap_max = 0;
          1:       in_gap_max = 14;
          default: in_gap_max = 3;
        endcase
        case ($urandom_range(0, 2))
          0:       out_gap_max = 0;
          1:       out_gap_max = 14;
          default: out_gap_max = 3;
        endcase
        if ($urandom_range(0, 4) != 0) begin
          random_frame();
        end else begin
          if ($urandom_range(0, 1) != 0) send_start();
          send_noise();
        end
        // Hold the samples back once until every pending report is out.
        if (!pressed && (samples_sent - phase_base) >= ITEMS_PER_PHASE / 2) begin
          settle();
          pressed = 1'b1;
        end
      end
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pdir_pkg.sv
rtl/pdir_cfg_regs.sv
rtl/pdir_queue.sv
rtl/pdir_decoder.sv
rtl/pulse_distance_ir_frame_receiver_core.sv
tb/tb_pulse_distance_ir_frame_receiver_core.sv
